@@ rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and constants of the six-byte utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 31;
	localparam int unsigned CntW  = 3;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [CpW-1:0]   cp_t;
	typedef logic [CntW-1:0]  cnt_t;

	typedef enum logic [1:0] {
		ST_CHAR    = 2'd0,
		ST_INVALID = 2'd1,
		ST_END     = 2'd2
	} status_t;

endpackage

@@ rtl/u8d_if.sv @@
// ----------------------------------------------------------------------------
// u8d_in_if / u8d_out_if
// valid/ready channels for encoded bytes and decoded characters
// ----------------------------------------------------------------------------
interface u8d_in_if import u8d_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  end_of_input;

	modport source (output valid, data_byte, end_of_input, input ready);
	modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
	logic    valid;
	logic    ready;
	cp_t     code_point;
	status_t status;

	modport source (output valid, code_point, status, input ready);
	modport sink   (input valid, code_point, status, output ready);
endinterface

@@ rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial decoder for the original six-byte utf-8 form
// ----------------------------------------------------------------------------
//  channel | direction | payload                      | handshake
//  enc     | in        | data_byte[8], end_of_input   | valid/ready
//  dec     | out       | code_point[31], status[2]    | valid/ready
//
//  one byte per cycle unless a stalled result holds the input: input register, decode, result register
//  an accepted byte is held in the input register and its result is registered in the result register
//  lead bytes that start a sequence and inner continuation bytes give no result
//  arst_n clears the sequence state and both valid flags
//  a stalled result holds only the input register; that stage still drains
//  when its byte gives no result
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	u8d_in_if.sink       enc,
	u8d_out_if.source    dec
);

	logic    valid_s1;
	byte_t   byte_s1;
	logic    end_s1;

	cnt_t    remain_q;
	cp_t     partial_q;

	logic    out_valid_q;
	cp_t     out_cp_q;
	status_t out_status_q;

	logic    has_res;
	cp_t     res_cp;
	status_t res_status;
	cnt_t    remain_d;
	cp_t     partial_d;
	logic    out_free;
	logic    adv_s1;
	cp_t     shifted;

	assign out_free  = !out_valid_q || dec.ready;
	assign adv_s1    = valid_s1 && (!has_res || out_free);
	assign enc.ready = !valid_s1 || adv_s1;
	assign shifted   = {partial_q[CpW-7:0], byte_s1[5:0]};

	always_comb begin
		has_res    = 1'b0;
		res_cp     = '0;
		res_status = ST_CHAR;
		remain_d   = remain_q;
		partial_d  = partial_q;
		if (end_s1) begin
			has_res    = 1'b1;
			res_status = ST_END;
			remain_d   = '0;
			partial_d  = '0;
		end else if (remain_q == '0) begin
			if (byte_s1[7:1] == 7'b1111110) begin
				partial_d = cp_t'(byte_s1[0]);
				remain_d  = cnt_t'(5);
			end else if (byte_s1[7:2] == 6'b111110) begin
				partial_d = cp_t'(byte_s1[1:0]);
				remain_d  = cnt_t'(4);
			end else if (byte_s1[7:3] == 5'b11110) begin
				partial_d = cp_t'(byte_s1[2:0]);
				remain_d  = cnt_t'(3);
			end else if (byte_s1[7:4] == 4'b1110) begin
				partial_d = cp_t'(byte_s1[3:0]);
				remain_d  = cnt_t'(2);
			end else if (byte_s1[7:5] == 3'b110) begin
				partial_d = cp_t'(byte_s1[4:0]);
				remain_d  = cnt_t'(1);
			end else if (byte_s1[7]) begin
				has_res    = 1'b1;
				res_status = ST_INVALID;
			end else begin
				has_res = 1'b1;
				res_cp  = cp_t'(byte_s1);
			end
		end else if (byte_s1[7:6] != 2'b10) begin
			has_res    = 1'b1;
			res_status = ST_INVALID;
			remain_d   = '0;
			partial_d  = '0;
		end else if (remain_q == cnt_t'(1)) begin
			has_res   = 1'b1;
			res_cp    = shifted;
			remain_d  = '0;
			partial_d = '0;
		end else begin
			partial_d = shifted;
			remain_d  = remain_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			remain_q    <= '0;
			partial_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (enc.ready) begin
				valid_s1 <= enc.valid;
			end
			if (adv_s1) begin
				remain_q  <= remain_d;
				partial_q <= partial_d;
			end
			if (adv_s1 && has_res) begin
				out_valid_q <= 1'b1;
			end else if (dec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc.ready && enc.valid) begin
			byte_s1 <= enc.data_byte;
			end_s1  <= enc.end_of_input;
		end
		if (adv_s1 && has_res) begin
			out_cp_q     <= res_cp;
			out_status_q <= res_status;
		end
	end

	assign dec.valid      = out_valid_q;
	assign dec.code_point = out_cp_q;
	assign dec.status     = out_status_q;

endmodule

@@ rtl/u8d_checker.sv @@
// ----------------------------------------------------------------------------
// u8d_checker
// port-level checks of the utf-8 stream decoder, bound into utf8_stream_decoder
// ----------------------------------------------------------------------------
module u8d_checker import u8d_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input cp_t     out_cp,
	input status_t out_status
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cp) && $stable(out_status))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == ST_CHAR || out_status == ST_INVALID
			|| out_status == ST_END)
		else $error("unknown status code");

	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_CHAR |-> out_cp == '0)
		else $error("code point not zero on non-character result");

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dec.valid),
	.out_ready  (dec.ready),
	.out_cp     (dec.code_point),
	.out_status (dec.status)
);
